### hdl/hcs_pkg.sv
// ----------------------------------------------------------------------------
// hcs_pkg: shared types and constants for the highly composite number search
// primes, widths and the command/status structs between control and datapath
// ----------------------------------------------------------------------------
package hcs_pkg;

  localparam int unsigned LimW = 63;
  localparam int unsigned CntW = 18;
  localparam int unsigned ExpW = 7;
  localparam int unsigned PrimeW = 7;

  typedef logic [LimW-1:0] lim_t;
  typedef logic [CntW-1:0] cnt_t;
  typedef logic [ExpW-1:0] exp_t;
  typedef logic [PrimeW-1:0] prime_t;

  function automatic prime_t prime_at(input logic [4:0] idx);
    prime_t p;
    begin
      unique case (idx)
        5'd0:  p = 7'd2;
        5'd1:  p = 7'd3;
        5'd2:  p = 7'd5;
        5'd3:  p = 7'd7;
        5'd4:  p = 7'd11;
        5'd5:  p = 7'd13;
        5'd6:  p = 7'd17;
        5'd7:  p = 7'd19;
        5'd8:  p = 7'd23;
        5'd9:  p = 7'd29;
        5'd10: p = 7'd31;
        5'd11: p = 7'd37;
        5'd12: p = 7'd41;
        5'd13: p = 7'd43;
        5'd14: p = 7'd47;
        5'd15: p = 7'd53;
        5'd16: p = 7'd59;
        5'd17: p = 7'd61;
        5'd18: p = 7'd67;
        5'd19: p = 7'd71;
        default: p = 7'd2;
      endcase
      return p;
    end
  endfunction

  // controller to datapath
  typedef struct packed {
    logic start;  // load limit, reset best, push root
    logic read;   // latch the parent exponent bound for the top frame
    logic eval;   // compute the node step from the read frame
    logic commit; // write back the result of the step
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic empty;  // no live frames
    logic child;  // a child frame waits to be pushed
  } dp_sts_t;

endpackage

### hdl/hcs_ram.sv
// ----------------------------------------------------------------------------
// hcs_ram: generic single write, single read port ram
// registered read data, contents undefined until written
// ----------------------------------------------------------------------------
module hcs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hdl/hcs_datapath.sv
// ----------------------------------------------------------------------------
// hcs_datapath: frame stack, exact bound test, product and count update
// one node step takes read, eval, commit and child push cycles
// ----------------------------------------------------------------------------
module hcs_datapath #(
  parameter int unsigned NumPrimes   = 20,
  parameter int unsigned MaxExponent = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  hcs_pkg::dp_cmd_t cmd_i,
  output hcs_pkg::dp_sts_t sts_o,
  input  hcs_pkg::lim_t    limit_i,
  output hcs_pkg::lim_t    best_number_o,
  output hcs_pkg::cnt_t    best_count_o
);
  import hcs_pkg::*;

  localparam int unsigned DepthW = $clog2(NumPrimes + 1);
  localparam int unsigned AddrW  = (NumPrimes > 1) ? $clog2(NumPrimes) : 1;
  localparam int unsigned FrameW = LimW + ExpW + CntW;

  logic [DepthW-1:0] depth_q, depth_d;
  lim_t              limit_q;
  lim_t              best_num_q;
  cnt_t              best_cnt_q;
  exp_t              parent_exp_q;   // exponent of the frame below top
  exp_t              exp_stack_q [NumPrimes];

  logic [AddrW-1:0]  top_addr;
  logic [FrameW-1:0] rd_frame, wr_frame;
  logic              we;
  logic [AddrW-1:0]  waddr;

  // eval results
  lim_t  prod_q;
  logic  prod_ok_q;
  exp_t  exp_new_q;
  cnt_t  cnt_q;
  cnt_t  base_cnt_q;  // count before this level's prime, kept in the frame
  logic  can_grow_q;
  logic [DepthW-1:0] lvl_q;

  lim_t  f_prod;
  exp_t  f_exp;
  cnt_t  f_cnt;
  exp_t  bound;
  logic [LimW+PrimeW-1:0] wide_prod;
  logic [LimW+PrimeW-1:0] wide_cnt;

  assign top_addr = AddrW'(depth_q - DepthW'(1));
  assign {f_prod, f_exp, f_cnt} = rd_frame;

  hcs_ram #(.Width(FrameW), .Depth(NumPrimes)) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wr_frame),
    .raddr_i(top_addr),
    .rdata_o(rd_frame)
  );

  always_comb begin
    bound = (depth_q == DepthW'(1)) ? ExpW'(MaxExponent) : parent_exp_q;
    // product fits iff product * p <= limit, exact since 63x7 bits is 70 bits
    wide_prod = (LimW+PrimeW)'(f_prod) * (LimW+PrimeW)'(prime_at(5'(top_addr)));
    wide_cnt  = (LimW+PrimeW)'(f_cnt) * (LimW+PrimeW)'(f_exp + ExpW'(2));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      prod_q     <= wide_prod[LimW-1:0];
      prod_ok_q  <= (f_exp < bound) && (wide_prod <= (LimW+PrimeW)'(limit_q));
      exp_new_q  <= f_exp + ExpW'(1);
      cnt_q      <= wide_cnt[CntW-1:0];
      base_cnt_q <= f_cnt;
      lvl_q      <= depth_q;
    end
  end

  assign can_grow_q = prod_ok_q;

  // commit: grow writes the updated frame, then pushes a child if room; no grow pops
  logic push_child_q;
  always_comb begin
    we       = 1'b0;
    waddr    = top_addr;
    wr_frame = {prod_q, exp_new_q, base_cnt_q};
    depth_d  = depth_q;
    if (cmd_i.start) begin
      we       = 1'b1;
      waddr    = '0;
      wr_frame = {LimW'(1), ExpW'(0), CntW'(1)};
      depth_d  = DepthW'(1);
    end else if (cmd_i.commit) begin
      if (!push_child_q) begin
        if (can_grow_q) begin
          we = 1'b1;
          depth_d = (lvl_q < DepthW'(NumPrimes)) ? depth_q + DepthW'(1) : depth_q;
        end else begin
          depth_d = depth_q - DepthW'(1);
        end
      end else begin
        we       = 1'b1;
        waddr    = AddrW'(lvl_q);
        wr_frame = {prod_q, ExpW'(0), cnt_q};
      end
    end
  end

  // child frame written in the cycle after the parent update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q      <= '0;
      push_child_q <= 1'b0;
    end else begin
      depth_q      <= depth_d;
      push_child_q <= cmd_i.commit && !push_child_q && can_grow_q &&
                      (lvl_q < DepthW'(NumPrimes));
    end
  end

  // exponent shadow per level supplies the parent bound without a second read
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      limit_q    <= limit_i;
      best_num_q <= LimW'(1);
      best_cnt_q <= CntW'(1);
    end else if (cmd_i.commit && !push_child_q && can_grow_q) begin
      exp_stack_q[top_addr] <= exp_new_q;
      if (cnt_q > best_cnt_q || (cnt_q == best_cnt_q && prod_q < best_num_q)) begin
        best_num_q <= prod_q;
        best_cnt_q <= cnt_q;
      end
    end else if (cmd_i.commit && push_child_q) begin
      exp_stack_q[AddrW'(lvl_q)] <= '0;
    end
    if (cmd_i.read) begin
      parent_exp_q <= (depth_q > DepthW'(1)) ? exp_stack_q[AddrW'(depth_q - DepthW'(2))]
                                             : ExpW'(MaxExponent);
    end
  end

  assign sts_o.empty   = (depth_q == '0);
  assign sts_o.child   = push_child_q;
  assign best_number_o = best_num_q;
  assign best_count_o  = best_cnt_q;

endmodule

### hdl/hcs_ctrl.sv
// ----------------------------------------------------------------------------
// hcs_ctrl: search sequencer
// accepts a limit, steps the datapath node by node, hands over the result
// ----------------------------------------------------------------------------
module hcs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hcs_pkg::dp_cmd_t cmd_o,
  input  hcs_pkg::dp_sts_t sts_i
);
  import hcs_pkg::*;

  typedef enum logic [5:0] {
    StIdle   = 6'b000001,
    StRead   = 6'b000010,
    StEval   = 6'b000100,
    StCommit = 6'b001000,
    StChild  = 6'b010000,
    StDone   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    in_ready_o  = (state_q == StIdle);
    out_valid_o = (state_q == StDone);
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d = StRead;
        end
      end
      StRead: begin
        if (sts_i.empty) begin
          state_d = StDone;
        end else begin
          cmd_o.read = 1'b1;
          state_d = StEval;
        end
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        state_d = StCommit;
      end
      StCommit: begin
        cmd_o.commit = 1'b1;
        state_d = StChild;
      end
      StChild: begin
        // second commit cycle pushes the child frame when one was queued
        cmd_o.commit = sts_i.child;
        state_d = StRead;
      end
      StDone: begin
        if (out_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hdl/highly_composite_search.sv
// ----------------------------------------------------------------------------
// highly_composite_search: highly composite number search
// smallest number <= limit with the most divisors, by depth-first search over
// non-increasing prime exponents on a frame stack
// ----------------------------------------------------------------------------
//  channel   dir  word
//  s_axis    in   tdata[62:0] query_limit_value
//  m_axis    out  tdata[62:0] best_number, [80:63] divisor_count
//
//  each stack step, a grow or a pop, runs read, eval, commit and child push;
//  a limit is accepted, searched and then handed out, the search time set by
//  the read, update and write-back of one stack frame per step
//  reset clears control only; the stack needs no clearing
//  one limit at a time; the result holds until m_axis_tready
// ----------------------------------------------------------------------------
module highly_composite_search #(
  parameter int unsigned NumPrimes   = 20,
  parameter int unsigned MaxExponent = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // query_limit_value[62:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata   // best_number[62:0], divisor_count[80:63]
);
  import hcs_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  lim_t    best_num;
  cnt_t    best_cnt;

  hcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  hcs_datapath #(.NumPrimes(NumPrimes), .MaxExponent(MaxExponent)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .limit_i      (s_axis_tdata[LimW-1:0]),
    .best_number_o(best_num),
    .best_count_o (best_cnt)
  );

  assign m_axis_tdata = {7'd0, best_cnt, best_num};

  a_one_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.start, cmd.read, cmd.eval}))
    else $error("more than one datapath command");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("accepting while result pending");
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> sts.empty)
    else $error("result with live frames");
  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> best_cnt != '0)
    else $error("zero divisor count");

endmodule
